// ===== design/sgrq_pkg.sv =====
package sgrq_pkg;

    localparam int GRID_CELLS   = 16;   // power of two, wraps by masking
    localparam int GRID_BITS    = $clog2(GRID_CELLS);
    localparam int BKT_BITS     = 2 * GRID_BITS;
    localparam int NUM_BUCKETS  = GRID_CELLS * GRID_CELLS;
    localparam int BUCKET_SLOTS = 4;
    localparam int SLOT_BITS    = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
    localparam int FILL_BITS    = $clog2(BUCKET_SLOTS + 1);
    localparam int PT_ADDR_BITS = BKT_BITS + SLOT_BITS;
    localparam int PT_DEPTH     = 1 << PT_ADDR_BITS;
    localparam int MAX_MATCHES  = 64;
    localparam int CNT_BITS     = $clog2(MAX_MATCHES + 1);
    localparam int COORD_BITS   = 16;
    localparam int DIV_STEPS    = COORD_BITS;
    localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_QUERY  = 1'b1
    } action_t;

    // One classified item on its way from the front to the back
    typedef struct packed {
        action_t               action;
        logic [COORD_BITS-1:0] pos_x;
        logic [COORD_BITS-1:0] pos_y;
        logic [COORD_BITS-1:0] radius;
        logic [GRID_BITS-1:0]  cell_u;   // insert: target cell; query: window start
        logic [GRID_BITS-1:0]  cell_v;
        logic [GRID_BITS-1:0]  span_m1;  // query window width minus one
    } job_t;

    typedef struct packed {
        logic                  found;
        logic [COORD_BITS-1:0] match_x;
        logic [COORD_BITS-1:0] match_y;
        logic                  accepted;
        logic                  truncated;
        logic                  last;
    } result_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } front_state_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_INS_RD,
        B_INS_WR,
        B_Q_START,
        B_CELL_RD,
        B_CELL_CHK,
        B_PT_RD,
        B_PT_MUL,
        B_PT_CMP,
        B_DONE
    } back_state_t;

endpackage

// ===== design/sgrq_front.sv =====
module sgrq_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [15:0]                    cell_size,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  sgrq_pkg::action_t              in_action,
    input  logic [sgrq_pkg::COORD_BITS-1:0] in_pos_x,
    input  logic [sgrq_pkg::COORD_BITS-1:0] in_pos_y,
    input  logic [sgrq_pkg::COORD_BITS-1:0] in_radius,
    output logic                           push,
    output sgrq_pkg::job_t                 job,
    input  logic                           q_full
);
    import sgrq_pkg::*;

    front_state_t            state_reg, state_next;
    action_t                 act_reg, act_next;
    logic [COORD_BITS-1:0]   px_reg, px_next, py_reg, py_next, rad_reg, rad_next;
    logic [COORD_BITS-1:0]   qx_reg, qx_next, qy_reg, qy_next, qr_reg, qr_next;
    logic [COORD_BITS-1:0]   rx_reg, rx_next, ry_reg, ry_next, rr_reg, rr_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [COORD_BITS-1:0]   cs;
    logic [COORD_BITS:0]     scan;
    logic [COORD_BITS+1:0]   scan2;
    logic                    whole;
    logic [GRID_BITS-1:0]    cu, cv;

    // One restoring division step: shift in the next dividend bit
    function automatic logic [2*COORD_BITS-1:0] div_step(
        input logic [COORD_BITS-1:0] rem,
        input logic [COORD_BITS-1:0] quo,
        input logic [COORD_BITS-1:0] dvs
    );
        logic [COORD_BITS:0] t;
        logic                ge;
        logic [COORD_BITS:0] d;
        t  = {rem, quo[COORD_BITS-1]};
        ge = (t >= {1'b0, dvs});
        d  = ge ? (t - {1'b0, dvs}) : t;
        return {d[COORD_BITS-1:0], quo[COORD_BITS-2:0], ge};
    endfunction

    assign cs    = (cell_size == '0) ? COORD_BITS'(1) : cell_size;
    assign cu    = qx_reg[GRID_BITS-1:0];
    assign cv    = qy_reg[GRID_BITS-1:0];
    assign scan  = {1'b0, qr_reg} + (COORD_BITS+1)'(1);
    assign scan2 = {scan, 1'b0};
    assign whole = (scan2 >= (COORD_BITS+2)'(GRID_CELLS));
    assign in_ready = (state_reg == F_IDLE);

    always_comb
    begin
        job.action = act_reg;
        job.pos_x  = px_reg;
        job.pos_y  = py_reg;
        job.radius = rad_reg;
        if (act_reg == ACT_INSERT)
        begin
            job.cell_u  = cu;
            job.cell_v  = cv;
            job.span_m1 = '0;
        end
        else if (whole)
        begin
            job.cell_u  = '0;
            job.cell_v  = '0;
            job.span_m1 = GRID_BITS'(GRID_CELLS - 1);
        end
        else
        begin
            job.cell_u  = cu - scan[GRID_BITS-1:0];
            job.cell_v  = cv - scan[GRID_BITS-1:0];
            job.span_m1 = scan2[GRID_BITS-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        act_next = act_reg;
        px_next = px_reg;
        py_next = py_reg;
        rad_next = rad_reg;
        qx_next = qx_reg;
        qy_next = qy_reg;
        qr_next = qr_reg;
        rx_next = rx_reg;
        ry_next = ry_reg;
        rr_next = rr_reg;
        cnt_next = cnt_reg;
        push = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    act_next = in_action;
                    px_next = in_pos_x;
                    py_next = in_pos_y;
                    rad_next = in_radius;
                    qx_next = in_pos_x;
                    qy_next = in_pos_y;
                    qr_next = in_radius;
                    rx_next = '0;
                    ry_next = '0;
                    rr_next = '0;
                    cnt_next = '0;
                    state_next = F_DIV;
                end
            end
            F_DIV:
            begin
                {rx_next, qx_next} = div_step(rx_reg, qx_reg, cs);
                {ry_next, qy_next} = div_step(ry_reg, qy_reg, cs);
                {rr_next, qr_next} = div_step(rr_reg, qr_reg, cs);
                cnt_next = cnt_reg + DIV_CNT_BITS'(1);
                if (cnt_reg == DIV_CNT_BITS'(DIV_STEPS - 1))
                    state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    push = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        act_reg <= act_next;
        px_reg <= px_next;
        py_reg <= py_next;
        rad_reg <= rad_next;
        qx_reg <= qx_next;
        qy_reg <= qy_next;
        qr_reg <= qr_next;
        rx_reg <= rx_next;
        ry_reg <= ry_next;
        rr_reg <= rr_next;
        cnt_reg <= cnt_next;
    end

endmodule

// ===== design/sgrq_fifo.sv =====
module sgrq_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  sgrq_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output sgrq_pkg::job_t head
);
    import sgrq_pkg::*;

    job_t       slot_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign head      = slot_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            if (push && !pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wp_reg] <= push_job;
    end

endmodule

// ===== design/sgrq_back.sv =====
module sgrq_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  sgrq_pkg::job_t    q_job,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output sgrq_pkg::result_t out_data
);
    import sgrq_pkg::*;

    back_state_t             state_reg, state_next;
    job_t                    job_reg, job_next;
    logic [GRID_BITS-1:0]    i_reg, i_next, j_reg, j_next;
    logic [SLOT_BITS-1:0]    s_reg, s_next;
    logic [FILL_BITS-1:0]    n_reg, n_next;
    logic [CNT_BITS-1:0]     cnt_reg, cnt_next;
    logic [31:0]             r2_reg, r2_next, dx2_reg, dx2_next, dy2_reg, dy2_next;
    logic [COORD_BITS-1:0]   ox_reg, ox_next, oy_reg, oy_next;
    logic [COORD_BITS-1:0]   pend_x_reg, pend_x_next, pend_y_reg, pend_y_next;
    logic                    pend_reg, pend_next, acc_reg, acc_next;
    logic                    trunc_reg, trunc_next;
    logic                    out_valid_reg;
    result_t                 out_reg, out_word;
    logic                    out_push, out_free, ins_wr;

    logic [FILL_BITS-1:0]    fill_mem [NUM_BUCKETS];
    logic                    fill_vld_reg [NUM_BUCKETS];
    logic [31:0]             pt_mem [PT_DEPTH];
    logic [FILL_BITS-1:0]    fill_dat_reg;
    logic                    fill_ok_reg;
    logic [31:0]             pt_dat_reg;

    logic [GRID_BITS-1:0]    uu, vv;
    logic [BKT_BITS-1:0]     cur_b;
    logic [FILL_BITS-1:0]    n_eff, s_inc;
    logic [COORD_BITS-1:0]   pt_x, pt_y, dx, dy;
    logic                    hit, last_cell, last_slot;
    logic [GRID_BITS-1:0]    adv_i, adv_j;
    back_state_t             adv_state;

    assign uu    = job_reg.cell_u + j_reg;
    assign vv    = job_reg.cell_v + i_reg;
    assign cur_b = {vv, uu};
    assign n_eff = fill_ok_reg ? fill_dat_reg : '0;
    assign s_inc = FILL_BITS'(s_reg) + FILL_BITS'(1);
    assign pt_x  = pt_dat_reg[COORD_BITS-1:0];
    assign pt_y  = pt_dat_reg[2*COORD_BITS-1:COORD_BITS];
    assign dx    = (pt_x > job_reg.pos_x) ? (pt_x - job_reg.pos_x) : (job_reg.pos_x - pt_x);
    assign dy    = (pt_y > job_reg.pos_y) ? (pt_y - job_reg.pos_y) : (job_reg.pos_y - pt_y);
    assign hit   = (({1'b0, dx2_reg} + {1'b0, dy2_reg}) <= {1'b0, r2_reg});
    assign last_cell = (i_reg == job_reg.span_m1) && (j_reg == job_reg.span_m1);
    assign last_slot = (s_inc == n_reg);
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Step to the next cell of the window, row by row
    always_comb
    begin
        adv_i = i_reg;
        adv_j = j_reg + GRID_BITS'(1);
        adv_state = B_CELL_RD;
        if (j_reg == job_reg.span_m1)
        begin
            adv_j = '0;
            adv_i = i_reg + GRID_BITS'(1);
        end
        if (last_cell)
            adv_state = B_DONE;
    end

    always_comb
    begin
        state_next = state_reg;
        job_next = job_reg;
        i_next = i_reg;
        j_next = j_reg;
        s_next = s_reg;
        n_next = n_reg;
        cnt_next = cnt_reg;
        r2_next = r2_reg;
        dx2_next = dx2_reg;
        dy2_next = dy2_reg;
        ox_next = ox_reg;
        oy_next = oy_reg;
        pend_x_next = pend_x_reg;
        pend_y_next = pend_y_reg;
        pend_next = pend_reg;
        acc_next = acc_reg;
        trunc_next = trunc_reg;
        q_pop = 1'b0;
        ins_wr = 1'b0;
        out_push = 1'b0;
        out_word = '0;
        case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    job_next = q_job;
                    i_next = '0;
                    j_next = '0;
                    s_next = '0;
                    cnt_next = '0;
                    pend_next = 1'b0;
                    acc_next = 1'b0;
                    trunc_next = 1'b0;
                    state_next = (q_job.action == ACT_INSERT) ? B_INS_RD : B_Q_START;
                end
            end
            B_INS_RD: state_next = B_INS_WR;
            B_INS_WR:
            begin
                if (n_eff < FILL_BITS'(BUCKET_SLOTS))
                begin
                    ins_wr = 1'b1;
                    acc_next = 1'b1;
                end
                state_next = B_DONE;
            end
            B_Q_START:
            begin
                r2_next = {16'b0, job_reg.radius} * {16'b0, job_reg.radius};
                state_next = B_CELL_RD;
            end
            B_CELL_RD: state_next = B_CELL_CHK;
            B_CELL_CHK:
            begin
                n_next = n_eff;
                s_next = '0;
                if (n_eff == '0)
                begin
                    i_next = adv_i;
                    j_next = adv_j;
                    state_next = adv_state;
                end
                else
                    state_next = B_PT_RD;
            end
            B_PT_RD: state_next = B_PT_MUL;
            B_PT_MUL:
            begin
                dx2_next = {16'b0, dx} * {16'b0, dx};
                dy2_next = {16'b0, dy} * {16'b0, dy};
                ox_next = pt_x;
                oy_next = pt_y;
                state_next = B_PT_CMP;
            end
            B_PT_CMP:
            begin
                // hold while an older match still waits for the output slot
                if (!(hit && pend_reg && !out_free))
                begin
                    if (hit)
                    begin
                        if (pend_reg)
                        begin
                            out_push = 1'b1;
                            out_word.found = 1'b1;
                            out_word.match_x = pend_x_reg;
                            out_word.match_y = pend_y_reg;
                        end
                        pend_next = 1'b1;
                        pend_x_next = ox_reg;
                        pend_y_next = oy_reg;
                        cnt_next = cnt_reg + CNT_BITS'(1);
                    end
                    if (hit && (cnt_reg == CNT_BITS'(MAX_MATCHES - 1)))
                    begin
                        trunc_next = 1'b1;
                        state_next = B_DONE;
                    end
                    else if (last_slot)
                    begin
                        i_next = adv_i;
                        j_next = adv_j;
                        state_next = adv_state;
                    end
                    else
                    begin
                        s_next = s_inc[SLOT_BITS-1:0];
                        state_next = B_PT_RD;
                    end
                end
            end
            B_DONE:
            begin
                if (out_free)
                begin
                    out_push = 1'b1;
                    out_word.found = pend_reg;
                    out_word.match_x = pend_reg ? pend_x_reg : '0;
                    out_word.match_y = pend_reg ? pend_y_reg : '0;
                    out_word.accepted = acc_reg;
                    out_word.truncated = trunc_reg;
                    out_word.last = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < NUM_BUCKETS; k++)
                fill_vld_reg[k] <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_push)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (ins_wr)
                fill_vld_reg[cur_b] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        i_reg <= i_next;
        j_reg <= j_next;
        s_reg <= s_next;
        n_reg <= n_next;
        cnt_reg <= cnt_next;
        r2_reg <= r2_next;
        dx2_reg <= dx2_next;
        dy2_reg <= dy2_next;
        ox_reg <= ox_next;
        oy_reg <= oy_next;
        pend_x_reg <= pend_x_next;
        pend_y_reg <= pend_y_next;
        pend_reg <= pend_next;
        acc_reg <= acc_next;
        trunc_reg <= trunc_next;
        if (out_push)
            out_reg <= out_word;
    end

    // Bucket fill counts and point slots
    always_ff @(posedge clk)
    begin
        fill_dat_reg <= fill_mem[cur_b];
        fill_ok_reg <= fill_vld_reg[cur_b];
        pt_dat_reg <= pt_mem[{cur_b, s_reg}];
        if (ins_wr)
        begin
            fill_mem[cur_b] <= n_eff + FILL_BITS'(1);
            pt_mem[{cur_b, n_eff[SLOT_BITS-1:0]}] <= {job_reg.pos_y, job_reg.pos_x};
        end
    end

endmodule

// ===== design/spatial_grid_radius_query.sv =====
// Wrapping uniform grid of 2D point buckets with insert and radius query.
// Input stream (s_*): one transfer per item; s_tuser selects insert (0) or
// query (1), s_tdata carries the point or query centre and the radius.
// Output stream (m_*): an insert gives one transfer (accepted flag); a query gives
// one transfer per matching stored point (at most 64, truncated set at the limit),
// or one empty transfer if nothing matches; m_tlast marks each item's last transfer.
// Configuration: APB register 0 at address 0 holds cell_size (0 acts as 1).
// Write it only while the block is idle.
// Front: a 16-step divider per value, run on x, y and the radius in parallel, does
// the cell and window arithmetic, then hands the job to a two-entry queue.
// The back does an insert as a fill-count read, then a write; a query reads the fill
// count of each visited cell, then reads, squares and compares each stored point in
// it, up to the whole 16x16 grid; the walk over the window sets the item rate.
// Reset clears all bucket fill counts at once and sets cell_size to 16.
// A stall on m_tready holds the output register; the back keeps scanning
// until a second match is ready, then waits; the queue lets the front keep
// accepting and dividing new items until the queue is full.
module spatial_grid_radius_query (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // pos_x[15:0], pos_y[31:16], radius[47:32]
    input  logic        s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // match_x[15:0], match_y[31:16], accepted[32],
                                   // truncated[33], zero fill[39:34]
    output logic        m_tuser,   // found
    output logic        m_tlast
);
    import sgrq_pkg::*;

    logic [15:0] cell_size_reg;
    logic        push, q_full, q_valid, q_pop;
    job_t        push_job, q_job;
    result_t     res;

    // Configuration register: one write per completed access phase
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {16'b0, cell_size_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cell_size_reg <= 16'd16;
        else if (psel && penable && pwrite && (paddr[2] == 1'b0))
            cell_size_reg <= pwdata[15:0];
    end

    // Front: accept, divide, classify into insert cell or query window
    sgrq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cell_size (cell_size_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_action (action_t'(s_tuser)),
        .in_pos_x  (s_tdata[15:0]),
        .in_pos_y  (s_tdata[31:16]),
        .in_radius (s_tdata[47:32]),
        .push      (push),
        .job       (push_job),
        .q_full    (q_full)
    );

    // Queue between front and back
    sgrq_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (q_job)
    );

    // Back: bucket storage, insert, window scan and output register
    sgrq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_job     (q_job),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res)
    );

    assign m_tdata = {6'b0, res.truncated, res.accepted, res.match_y, res.match_x};
    assign m_tuser = res.found;
    assign m_tlast = res.last;

endmodule
